[sv/png_ihdr_chunk_generator_top_assert.svh]
// Assertion macros for the IHDR chunk generator.
// Clock is clk, reset is arst_n (active low) in every user of these macros.
`ifndef PNG_IHDR_CHUNK_GENERATOR_TOP_ASSERT_SVH
`define PNG_IHDR_CHUNK_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define PIHDR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pihdr assertion failed");

`define PIHDR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pihdr assertion failed");

`else

`define PIHDR_ASSERT(lbl, prop)

`define PIHDR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[sv/pihdr_pkg.sv]
`timescale 1ns / 1ps

package pihdr_pkg;

	localparam int unsigned CHUNK_BYTES = 25;
	localparam int unsigned HDR_BYTES   = 21;   // length, type and data

	localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [31:0] DATA_LENGTH = 32'd13;
	localparam logic [7:0]  FALLBACK_DEPTH = 8'd8;
	localparam logic [7:0]  BYTE_ZERO = 8'h00;

	// chunk type "IHDR"
	localparam logic [7:0] TYPE_I = 8'h49;
	localparam logic [7:0] TYPE_H = 8'h48;
	localparam logic [7:0] TYPE_D = 8'h44;
	localparam logic [7:0] TYPE_R = 8'h52;

	// byte positions within the chunk
	localparam logic [4:0] POS_FIRST  = 5'd0;
	localparam logic [4:0] POS_TYPE0  = 5'd4;
	localparam logic [4:0] POS_ILACE  = 5'd20;
	localparam logic [4:0] POS_CRC0   = 5'd21;
	localparam logic [4:0] POS_LAST   = 5'd24;

	// colour type codes
	localparam logic [7:0] CT_GREY       = 8'd0;
	localparam logic [7:0] CT_RGB        = 8'd2;
	localparam logic [7:0] CT_PALETTE    = 8'd3;
	localparam logic [7:0] CT_GREY_ALPHA = 8'd4;
	localparam logic [7:0] CT_RGBA       = 8'd6;

	typedef struct packed {
		logic init;     // preset the CRC register
		logic update;   // fold data_byte into the CRC
	} pihdr_crc_ctl_t;

	function automatic logic depth_ok(input logic [7:0] depth, input logic [7:0] ctype);
		logic ok;
		ok = 1'b0;
		case (ctype)
			CT_GREY:    ok = depth inside {8'd1, 8'd2, 8'd4, 8'd8, 8'd16};
			CT_PALETTE: ok = depth inside {8'd1, 8'd2, 8'd4, 8'd8};
			CT_RGB, CT_GREY_ALPHA, CT_RGBA: ok = depth inside {8'd8, 8'd16};
			default:    ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

[sv/pihdr_crc.sv]
`timescale 1ns / 1ps

// Byte-wide reflected CRC-32 register.
module pihdr_crc
	import pihdr_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  pihdr_crc_ctl_t ctl,
	input  logic [7:0]     data_byte,
	output logic [31:0]    crc
);

	logic [31:0] crc_q;
	logic [31:0] crc_next;

	// eight shift/xor steps, one per data bit
	always_comb begin
		crc_next = crc_q ^ {24'd0, data_byte};
		for (int k = 0; k < 8; k++) begin
			if (crc_next[0]) begin
				crc_next = (crc_next >> 1) ^ CRC_POLY;
			end else begin
				crc_next = crc_next >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_PRESET;
		end else if (ctl.init) begin
			crc_q <= CRC_PRESET;
		end else if (ctl.update) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;

endmodule

[sv/png_ihdr_chunk_generator_top.sv]
`timescale 1ns / 1ps
// Output: once start is taken the position counter is loaded, the first chunk byte is
//   formed from it and then held in the result register before it is on strobe; the other
//   24 bytes follow in consecutive cycles, last_byte marks the final CRC byte.
// Throughput: the next start is taken in the cycle the final byte is formed, so chunks
//   run back to back.
// Reset (arst_n low): idle, busy and strobe low, CRC register preset to all ones.
`include "png_ihdr_chunk_generator_top_assert.svh"

module png_ihdr_chunk_generator_top
	import pihdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] image_width,
	input  logic [31:0] image_height,
	input  logic [7:0]  bit_depth,
	input  logic [7:0]  color_type,
	input  logic [7:0]  interlace_method,
	output logic        strobe,
	output logic [7:0]  out_byte,
	output logic        last_byte
);

	// ---------------------------------------------------------------
	// Item capture. Fields are held for the whole chunk.
	// The depth byte is replaced by 8 here when it is not legal for
	// the colour type (or the colour type is unknown).
	// ---------------------------------------------------------------
	logic        accept;
	logic [31:0] width_q;
	logic [31:0] height_q;
	logic [7:0]  depth_q;
	logic [7:0]  ctype_q;
	logic [7:0]  ilace_q;

	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			width_q  <= image_width;
			height_q <= image_height;
			depth_q  <= depth_ok(bit_depth, color_type) ? bit_depth : FALLBACK_DEPTH;
			ctype_q  <= color_type;
			ilace_q  <= interlace_method;
		end
	end

	// ---------------------------------------------------------------
	// Byte position counter. busy drops while the last byte is being
	// formed so the next item overlaps with it.
	// ---------------------------------------------------------------
	logic       active_q;
	logic [4:0] pos_q;
	logic       at_last;

	assign at_last = (pos_q == POS_LAST);
	assign busy    = active_q && !at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= POS_FIRST;
		end else if (accept) begin
			active_q <= 1'b1;
			pos_q    <= POS_FIRST;
		end else if (active_q) begin
			if (at_last) begin
				active_q <= 1'b0;
				pos_q    <= POS_FIRST;
			end else begin
				pos_q <= pos_q + 5'd1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Chunk byte select: length, type and data come from a fixed map
	// over the held fields, the trailing four bytes from the CRC.
	// ---------------------------------------------------------------
	logic [7:0]  hdr [HDR_BYTES];
	logic [31:0] crc;
	logic [31:0] crc_fin;
	logic [1:0]  crc_idx;
	logic [7:0]  crc_byte;
	logic [7:0]  cur_byte;

	always_comb begin
		hdr[0]  = DATA_LENGTH[31:24];
		hdr[1]  = DATA_LENGTH[23:16];
		hdr[2]  = DATA_LENGTH[15:8];
		hdr[3]  = DATA_LENGTH[7:0];
		hdr[4]  = TYPE_I;
		hdr[5]  = TYPE_H;
		hdr[6]  = TYPE_D;
		hdr[7]  = TYPE_R;
		hdr[8]  = width_q[31:24];
		hdr[9]  = width_q[23:16];
		hdr[10] = width_q[15:8];
		hdr[11] = width_q[7:0];
		hdr[12] = height_q[31:24];
		hdr[13] = height_q[23:16];
		hdr[14] = height_q[15:8];
		hdr[15] = height_q[7:0];
		hdr[16] = depth_q;
		hdr[17] = ctype_q;
		hdr[18] = BYTE_ZERO;   // compression
		hdr[19] = BYTE_ZERO;   // filter
		hdr[20] = ilace_q;
	end

	assign crc_fin = crc ^ CRC_PRESET;
	assign crc_idx = 2'(pos_q - POS_CRC0);

	always_comb begin
		case (crc_idx)
			2'd0:    crc_byte = crc_fin[31:24];
			2'd1:    crc_byte = crc_fin[23:16];
			2'd2:    crc_byte = crc_fin[15:8];
			2'd3:    crc_byte = crc_fin[7:0];
			default: crc_byte = crc_fin[7:0];
		endcase
	end

	assign cur_byte = (pos_q <= POS_ILACE) ? hdr[pos_q] : crc_byte;

	// CRC covers type and data bytes; preset on every new item
	pihdr_crc_ctl_t crc_ctl;

	always_comb begin
		crc_ctl.init   = accept;
		crc_ctl.update = active_q && (pos_q >= POS_TYPE0) && (pos_q <= POS_ILACE);
	end

	pihdr_crc u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (crc_ctl),
		.data_byte (cur_byte),
		.crc       (crc)
	);

	// ---------------------------------------------------------------
	// Result register: one byte per cycle, no back-pressure.
	// ---------------------------------------------------------------
	logic       strobe_q;
	logic       last_q;
	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= active_q;
			last_q   <= active_q && at_last;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= cur_byte;
	end

	assign strobe    = strobe_q;
	assign last_byte = last_q;
	assign out_byte  = byte_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	logic first_pos;

	assign first_pos = active_q && (pos_q == POS_FIRST);

	// the first byte formed for a chunk is the top length byte
	`PIHDR_ASSERT_NEXT(a_first_byte, first_pos, strobe && !last_byte && out_byte == BYTE_ZERO)
	// bytes of one chunk are contiguous
	`PIHDR_ASSERT_NEXT(a_no_gap, strobe && !last_byte, strobe)
	// last flag only on a strobed byte
	`PIHDR_ASSERT(a_last_strobed, last_byte |-> strobe)

endmodule
